@@ rtl/rlts_pkg.sv @@
// Shared constants, payload structs and control structs of the register list sequencer.
package rlts_pkg;

	localparam int NUM_REGS   = 16;
	localparam int ADDR_WIDTH = 32;
	localparam int MASK_W     = 16;
	localparam int IDX_W      = $clog2(MASK_W);
	localparam int OUT_ADDR_W = 32;
	localparam int REGIX_W    = 4;
	localparam int AREG_W     = 3;
	localparam int S_TDATA_W  = 56;
	localparam int M_TDATA_W  = 80;

	localparam logic [ADDR_WIDTH-1:0] WORD_STEP = ADDR_WIDTH'(2);
	localparam logic [ADDR_WIDTH-1:0] LONG_STEP = ADDR_WIDTH'(4);

	// Mask bits at or above the register count take no part in a request.
	localparam int LIVE_BITS = (NUM_REGS < MASK_W) ? NUM_REGS : MASK_W;
	localparam logic [MASK_W-1:0] LIVE_MASK = MASK_W'((65'd1 << LIVE_BITS) - 65'd1);

	typedef struct packed {
		logic [AREG_W-1:0]     addr_reg;
		logic                  update_mode;
		logic                  long_size;
		logic [OUT_ADDR_W-1:0] base_addr;
		logic [MASK_W-1:0]     reg_mask;
		logic                  req_type;
	} req_t;

	typedef struct packed {
		logic [OUT_ADDR_W-1:0] final_addr;
		logic [AREG_W-1:0]     writeback_reg;
		logic                  writeback_en;
		logic                  last_access;
		logic                  long_access;
		logic                  is_write;
		logic [REGIX_W-1:0]    reg_index;
		logic [OUT_ADDR_W-1:0] access_addr;
		logic                  access_valid;
	} rslt_t;

	typedef struct packed {
		logic load;
		logic step;
	} cmd_t;

	typedef struct packed {
		logic out_free;
		logic last;
	} sts_t;

endpackage

@@ rtl/rlts_ctrl.sv @@
// Controller state machine that sequences one request through the datapath.
module rlts_ctrl
	import rlts_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	state_t state_q;

	assign req_ready = (state_q == ST_IDLE);
	assign cmd.load  = req_ready && req_valid;
	assign cmd.step  = (state_q == ST_RUN) && sts.out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (sts.out_free && sts.last) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

@@ rtl/rlts_dpath.sv @@
// Datapath: request registers, mask scan, address stepping and the result register.
module rlts_dpath
	import rlts_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  req_t  req,
	input  cmd_t  cmd,
	output sts_t  sts,
	output rslt_t rslt,
	output logic  rslt_valid,
	input  logic  rslt_ready
);

	logic [MASK_W-1:0]     mask_q;
	logic [ADDR_WIDTH-1:0] addr_q;
	logic                  load_q;
	logic                  long_q;
	logic                  upd_q;
	logic [AREG_W-1:0]     areg_q;
	rslt_t                 rslt_q;
	logic                  rslt_valid_q;

	logic [IDX_W-1:0]      bit_idx;
	logic [MASK_W-1:0]     mask_rest;
	logic                  predec;
	logic [ADDR_WIDTH-1:0] step_val;
	logic [ADDR_WIDTH-1:0] addr_dec;
	logic [ADDR_WIDTH-1:0] addr_inc;
	logic [ADDR_WIDTH-1:0] addr_next;
	logic [7:0]            rev_idx;
	rslt_t                 rslt_d;

	// Lowest set bit of the remaining mask.
	always_comb begin
		bit_idx = '0;
		for (int k = MASK_W - 1; k >= 0; k--) begin
			if (mask_q[k]) begin
				bit_idx = IDX_W'(k);
			end
		end
	end

	assign mask_rest = mask_q & (mask_q - MASK_W'(1));
	assign predec    = !load_q && upd_q;
	assign step_val  = long_q ? LONG_STEP : WORD_STEP;
	assign addr_dec  = addr_q - step_val;
	assign addr_inc  = addr_q + step_val;
	assign addr_next = predec ? addr_dec : addr_inc;
	assign rev_idx   = 8'(NUM_REGS - 1) - 8'(bit_idx);

	assign sts.out_free = !rslt_valid_q || rslt_ready;
	assign sts.last     = (mask_rest == '0);

	always_comb begin
		rslt_d = '0;
		if (mask_q == '0) begin
			// Empty mask: a single result without a bus access.
			rslt_d.last_access   = 1'b1;
			rslt_d.writeback_en  = upd_q;
			rslt_d.writeback_reg = areg_q;
			rslt_d.final_addr    = OUT_ADDR_W'(addr_q);
		end else begin
			rslt_d.access_valid = 1'b1;
			rslt_d.access_addr  = OUT_ADDR_W'(predec ? addr_dec : addr_q);
			rslt_d.reg_index    = predec ? rev_idx[REGIX_W-1:0] : REGIX_W'(bit_idx);
			rslt_d.is_write     = !load_q;
			rslt_d.long_access  = long_q;
			if (mask_rest == '0) begin
				rslt_d.last_access   = 1'b1;
				rslt_d.writeback_en  = upd_q;
				rslt_d.writeback_reg = areg_q;
				rslt_d.final_addr    = OUT_ADDR_W'(addr_next);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mask_q <= req.reg_mask & LIVE_MASK;
			addr_q <= ADDR_WIDTH'(req.base_addr);
			load_q <= req.req_type;
			long_q <= req.long_size;
			upd_q  <= req.update_mode;
			areg_q <= req.addr_reg;
		end else if (cmd.step && (mask_q != '0)) begin
			mask_q <= mask_rest;
			addr_q <= addr_next;
		end
		if (cmd.step) begin
			rslt_q <= rslt_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rslt_valid_q <= 1'b0;
		end else if (cmd.step) begin
			rslt_valid_q <= 1'b1;
		end else if (rslt_ready) begin
			rslt_valid_q <= 1'b0;
		end
	end

	assign rslt       = rslt_q;
	assign rslt_valid = rslt_valid_q;

endmodule

@@ rtl/register_list_transfer_sequencer_unit.sv @@
// Top level of the register list transfer sequencer.
// A request is loaded into the request registers on acceptance; its first result then goes to the result
// register once the output register is free. A request with n mask bits set gives max(n, 1) results,
// one result per cycle while the sink accepts them, and a new request is taken only after its last result.
// Reset: arst_n clears the controller state and the result valid flag asynchronously;
// no clearing pass is needed as the block keeps no state between requests.
module register_list_transfer_sequencer_unit
	import rlts_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// s_tdata from bit 0: reg_mask[15:0], base_addr[31:0], long_size, update_mode,
	// addr_reg[2:0], then three zero bits.
	input  logic [S_TDATA_W-1:0] s_tdata,
	// s_tuser: req_type (0 store, 1 load).
	input  logic                 s_tuser,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// m_tdata from bit 0: access_addr[31:0], reg_index[3:0], is_write, long_access,
	// writeback_en, writeback_reg[2:0], final_addr[31:0], then six zero bits.
	output logic [M_TDATA_W-1:0] m_tdata,
	// m_tuser: access_valid (0 marks the result of an empty mask).
	output logic                 m_tuser,
	// m_tlast: last_access, the final transfer of a request.
	output logic                 m_tlast
);

	req_t  req;
	cmd_t  cmd;
	sts_t  sts;
	rslt_t rslt;

	// Unpack the incoming request; the three top bits of s_tdata are padding.
	assign req.req_type    = s_tuser;
	assign req.reg_mask    = s_tdata[15:0];
	assign req.base_addr   = s_tdata[47:16];
	assign req.long_size   = s_tdata[48];
	assign req.update_mode = s_tdata[49];
	assign req.addr_reg    = s_tdata[52:50];

	// The controller only decides when to load a request and when to step it.
	rlts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (s_tvalid),
		.req_ready (s_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// The datapath walks the mask one set bit per step and holds the output register,
	// so a new request can be taken while the final transfer still waits at the sink.
	rlts_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.cmd        (cmd),
		.sts        (sts),
		.rslt       (rslt),
		.rslt_valid (m_tvalid),
		.rslt_ready (m_tready)
	);

	assign m_tuser = rslt.access_valid;
	assign m_tlast = rslt.last_access;
	assign m_tdata = {6'b0, rslt.final_addr, rslt.writeback_reg, rslt.writeback_en,
		rslt.long_access, rslt.is_write, rslt.reg_index, rslt.access_addr};

`ifndef SYNTHESIS
	// Once a request is taken, the next one waits until its final result is produced.
	a_one_request: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request accepted while another is still in progress");

	// The empty-mask result is always the only, and therefore last, transfer.
	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tlast)
		else $error("empty-mask result not marked last");

	// Write-back information appears on the last transfer only.
	a_wb_only_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> (m_tdata[73:38] == '0))
		else $error("write-back fields set on a transfer that is not last");
`endif

endmodule
